### rtl/wcrc3_pkg.sv
// Package for the word CRC-32 three-byte-step unit.
// Holds the polynomial, the register type and the constant advance columns for a 24-bit shift.
// No dependencies.
package wcrc3_pkg;

    localparam int unsigned CrcWidth  = 32;
    localparam int unsigned ByteSteps = 3;
    localparam int unsigned ShiftCnt  = 8 * ByteSteps;

    typedef logic [CrcWidth-1:0] crc_t;
    typedef crc_t crc_cols_t [CrcWidth];

    localparam crc_t CrcPoly = 32'h04C1_1DB7;
    localparam crc_t CrcMsb  = 32'h8000_0000;

    // Advance a register by one MSB-first shift, folding in the polynomial
    function automatic crc_t crc_shift1(input crc_t r);
        crc_shift1 = ((r & CrcMsb) != '0) ? ((r << 1) ^ CrcPoly) : (r << 1);
    endfunction

    // Build the columns of the linear map for three byte steps (elaboration only)
    function automatic crc_cols_t build_adv_cols();
        crc_cols_t cols;
        crc_t      r;
        for (int i = 0; i < CrcWidth; i++) begin
            r = crc_t'(1) << i;
            for (int k = 0; k < ShiftCnt; k++) begin
                r = crc_shift1(r);
            end
            cols[i] = r;
        end
        return cols;
    endfunction

    localparam crc_cols_t AdvCols = build_adv_cols();

    // Apply three byte steps as an XOR of constant columns, one per register bit
    function automatic crc_t crc_advance(input crc_t r);
        crc_t acc;
        acc = '0;
        for (int i = 0; i < CrcWidth; i++) begin
            if (r[i]) begin
                acc = acc ^ AdvCols[i];
            end
        end
        return acc;
    endfunction

endpackage

### rtl/word_crc32_three_byte_step_unit.sv
// Word CRC-32 unit: request register, CRC register and checksum register.
// Depends on wcrc3_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one request per word: data_word,
//   first_word (start of message) and last_word (end of message).
//   Output channel out_valid/out_ready carries checksum, one per last word.
//   A first word loads the CRC register with ~data_word; any other word
//   advances the register by three MSB-first CRC-32 byte steps (poly
//   0x04C11DB7) and XORs the word in. On a last word the inverted register
//   is sent, so a one-word message returns the word itself.
// Throughput: one word per cycle unless a last word stalls. The three
//   byte steps are a fixed XOR network between the request and CRC registers.
// Path: an accepted last word passes the request register, then its checksum
//   loads the checksum register, which holds it until out_ready takes it.
// Stall: when the checksum register is full and out_ready is low, a last
//   word in the request register holds, and in_ready drops until the
//   checksum is taken; words without a last mark keep flowing.
// Reset: the CRC register clears to zero, both registers empty. A word
//   without a first mark after reset advances from zero.
module word_crc32_three_byte_step_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  wcrc3_pkg::crc_t    data_word,
    input  logic               first_word,
    input  logic               last_word,
    output logic               out_valid,
    input  logic               out_ready,
    output wcrc3_pkg::crc_t    checksum
);
    import wcrc3_pkg::*;

    logic  stg_valid_reg;
    crc_t  stg_data_reg;
    logic  stg_first_reg;
    logic  stg_last_reg;
    crc_t  crc_reg;
    crc_t  crc_next;
    logic  out_valid_reg;
    crc_t  checksum_reg;
    logic  stg_fire;
    logic  in_fire;

    // Advance the request stage unless a last word waits on a full output
    assign stg_fire = stg_valid_reg && (!stg_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !stg_valid_reg || stg_fire;
    assign in_fire  = in_valid && in_ready;

    // Compute the next CRC register value
    always_comb
    begin
        if (stg_first_reg)
        begin
            crc_next = ~stg_data_reg;
        end
        else
        begin
            crc_next = crc_advance(crc_reg) ^ stg_data_reg;
        end
    end

    // Hold the request stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stg_data_reg  <= data_word;
            stg_first_reg <= first_word;
            stg_last_reg  <= last_word;
        end
    end

    // Update the CRC register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (stg_fire)
        begin
            crc_reg <= crc_next;
        end
    end

    // Track the checksum register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_fire && stg_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the inverted register on a last word
    always_ff @(posedge clk)
    begin
        if (stg_fire && stg_last_reg)
        begin
            checksum_reg <= ~crc_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;

endmodule

### rtl/wcrc3_checker.sv
// Port-level checker for the word CRC-32 unit, attached by bind.
// Depends on wcrc3_pkg and word_crc32_three_byte_step_unit.
module wcrc3_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input wcrc3_pkg::crc_t data_word,
    input logic            first_word,
    input logic            last_word,
    input logic            out_valid,
    input logic            out_ready,
    input wcrc3_pkg::crc_t checksum
);
    import wcrc3_pkg::*;

    // Hold a stalled checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(checksum))
        else $error("stalled checksum changed or dropped");

    // Drop in_ready only behind a waiting checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled without a pending checksum");

    // A new checksum follows an accepted last-word request through the request register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && last_word, 2))
        else $error("checksum without a last-word request");

    // A one-word message returns the word itself
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && $past(in_valid && in_ready && first_word && last_word, 2)
        |-> checksum == $past(data_word, 2))
        else $error("one-word checksum mismatch");

endmodule

bind word_crc32_three_byte_step_unit wcrc3_checker u_wcrc3_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .first_word (first_word),
    .last_word  (last_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .checksum   (checksum)
);
